// File: sv/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg
// shared widths, constants and codes for the graph cycle detector
// ----------------------------------------------------------------------------
package dcd_pkg;
	localparam int NODES = 1024;
	localparam int EDGES = 8192;
	localparam int NW = $clog2(NODES);
	localparam int EW = $clog2(EDGES);
	localparam int LW = EW + 1;
	localparam int CW = 11;

	typedef logic [NW-1:0] node_t;
	typedef logic [LW-1:0] link_t;
	typedef logic [1:0] mark_t;
	typedef logic [1:0] status_t;

	localparam mark_t MARK_UNVISITED = 2'd0;
	localparam mark_t MARK_ON_PATH = 2'd1;
	localparam mark_t MARK_DONE = 2'd2;

	localparam status_t ST_ACYCLIC = 2'd0;
	localparam status_t ST_CYCLE = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;
	localparam status_t ST_RANGE = 2'd3;

	localparam link_t NULL_LINK = link_t'(EDGES);
endpackage

// File: sv/dag_cycle_detect.sv
// ----------------------------------------------------------------------------
// dag_cycle_detect
// directed graph cycle detection by iterative depth-first walk
// ----------------------------------------------------------------------------
// Edges load into an edge store chained per source node; each load reads and
// rewrites the source list head, so an input transaction is a head read in
// idle, then a write in load. After reset and after every result, a clearing
// pass over all nodes resets list heads and marks while no transaction is
// accepted. The item flagged last starts the walk over the node, edge and
// stack memories: the root scan reads each node's mark (root, root check), a
// root takes one more stack check when its stack runs empty, a pop goes
// through stack read, check and mark done, and each edge through stack read,
// edge and node read and target check; the single result is then held in an
// output register until taken. Errors skip the walk: status 3 for an index at
// or beyond the clamped node count, 2 for a full edge store.
module dag_cycle_detect (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [dcd_pkg::CW-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  dcd_pkg::node_t source_node,
	input  dcd_pkg::node_t target_node,
	input  logic edge_present,
	input  logic last_item,
	output logic out_valid,
	input  logic out_ready,
	output logic acyclic,
	output dcd_pkg::status_t status
);
	import dcd_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LOAD, S_ROOT, S_ROOTCHK, S_TOP, S_TOPCHK,
		S_EDGE, S_TARGET, S_DONE, S_DONE_OUT
	} state_t;

	state_t state_q;
	logic [CW-1:0] cfg_q;
	logic [NW:0] n_use;
	logic [NW:0] clr_q;
	logic [NW:0] root_q;
	logic [NW:0] sp_q;
	logic [LW-1:0] edges_q;
	logic err_ovf_q, err_rng_q;
	logic last_q;
	node_t src_q, dst_q;
	link_t e_q;
	node_t u_q;
	status_t status_q;
	logic edge_ok_q;
	node_t v_q;

	// memory ports
	logic em_we, nm_we, sm_we;
	logic [EW-1:0] em_raddr;
	node_t em_rtarget;
	link_t em_rnext;
	node_t nm_waddr, nm_raddr;
	link_t nm_whead, nm_rhead;
	mark_t nm_wmark, nm_rmark;
	node_t sm_waddr, sm_raddr, sm_wnode, sm_rnode;
	link_t sm_wedge, sm_redge;

	// node count clamp: zero acts as one, above capacity acts as capacity
	always_comb begin
		if (cfg_q == '0) n_use = (NW+1)'(1);
		else if (cfg_q > CW'(NODES)) n_use = (NW+1)'(NODES);
		else n_use = cfg_q[NW:0];
	end

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == S_IDLE) && !out_valid;

	logic in_fire;
	assign in_fire = in_valid && in_ready;
	logic edge_ok;
	assign edge_ok = ({1'b0, source_node} < n_use) && ({1'b0, target_node} < n_use);

	node_t top_idx;
	assign top_idx = NW'(sp_q - (NW+1)'(1));

	dcd_edge_mem u_edge (
		.clk(clk), .we(em_we), .waddr(edges_q[EW-1:0]), .wtarget(dst_q),
		.wnext(nm_rhead), .raddr(em_raddr), .rtarget(em_rtarget), .rnext(em_rnext)
	);
	dcd_node_mem u_node (
		.clk(clk), .we(nm_we), .waddr(nm_waddr), .whead(nm_whead), .wmark(nm_wmark),
		.raddr(nm_raddr), .rhead(nm_rhead), .rmark(nm_rmark)
	);
	dcd_stack_mem u_stack (
		.clk(clk), .we(sm_we), .waddr(sm_waddr), .wnode(sm_wnode), .wedge(sm_wedge),
		.raddr(sm_raddr), .rnode(sm_rnode), .redge(sm_redge)
	);

	// memory control per state
	always_comb begin
		em_we = 1'b0;
		em_raddr = e_q[EW-1:0];
		nm_we = 1'b0;
		nm_waddr = src_q;
		nm_whead = NULL_LINK;
		nm_wmark = MARK_UNVISITED;
		nm_raddr = src_q;
		sm_we = 1'b0;
		sm_waddr = top_idx;
		sm_wnode = u_q;
		sm_wedge = NULL_LINK;
		sm_raddr = top_idx;
		unique case (state_q)
			S_CLEAR: begin
				nm_we = 1'b1;
				nm_waddr = clr_q[NW-1:0];
			end
			S_IDLE: nm_raddr = source_node;
			S_LOAD: begin
				// head read of the source issued in idle is valid now
				em_we = edge_ok_q;
				nm_we = edge_ok_q;
				nm_waddr = src_q;
				nm_whead = link_t'(edges_q);
				nm_wmark = MARK_UNVISITED;
			end
			S_ROOT: nm_raddr = root_q[NW-1:0];
			S_ROOTCHK: begin
				if (nm_rmark == MARK_UNVISITED) begin
					nm_we = 1'b1;
					nm_waddr = root_q[NW-1:0];
					nm_whead = nm_rhead;
					nm_wmark = MARK_ON_PATH;
					sm_we = 1'b1;
					sm_waddr = '0;
					sm_wnode = root_q[NW-1:0];
					sm_wedge = nm_rhead;
				end
			end
			S_TOP: sm_raddr = top_idx;
			S_TOPCHK: begin
				em_raddr = sm_redge[EW-1:0];
				nm_raddr = sm_rnode;
			end
			S_EDGE: begin
				// nm read holds the top node's head; edge data is valid now
				sm_we = 1'b1;
				sm_waddr = top_idx;
				sm_wnode = u_q;
				sm_wedge = em_rnext;
				nm_raddr = em_rtarget;
			end
			S_TARGET: begin
				if (nm_rmark == MARK_UNVISITED) begin
					nm_we = 1'b1;
					nm_waddr = v_q;
					nm_whead = nm_rhead;
					nm_wmark = MARK_ON_PATH;
					sm_we = 1'b1;
					sm_waddr = sp_q[NW-1:0];
					sm_wnode = v_q;
					sm_wedge = nm_rhead;
				end
			end
			S_DONE: begin
				// node read issued at the stack check still holds u's head
				nm_we = 1'b1;
				nm_waddr = u_q;
				nm_whead = nm_rhead;
				nm_wmark = MARK_DONE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cfg_q <= CW'(1);
			clr_q <= '0;
			edges_q <= '0;
			err_ovf_q <= 1'b0;
			err_rng_q <= 1'b0;
			out_valid <= 1'b0;
			root_q <= '0;
			sp_q <= '0;
			last_q <= 1'b0;
			edge_ok_q <= 1'b0;
			status_q <= ST_ACYCLIC;
		end else begin
			if (cfg_valid) cfg_q <= cfg_data;
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + (NW+1)'(1);
					if (clr_q == (NW+1)'(NODES - 1)) begin
						state_q <= S_IDLE;
						edges_q <= '0;
						err_ovf_q <= 1'b0;
						err_rng_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						src_q <= source_node;
						dst_q <= target_node;
						last_q <= last_item;
						edge_ok_q <= 1'b0;
						if (edge_present) begin
							if (!edge_ok) err_rng_q <= 1'b1;
							else if (edges_q >= LW'(EDGES)) err_ovf_q <= 1'b1;
							else edge_ok_q <= 1'b1;
						end
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (edge_ok_q) edges_q <= edges_q + LW'(1);
					if (!last_q) state_q <= S_IDLE;
					else if (err_rng_q) begin
						status_q <= ST_RANGE;
						state_q <= S_DONE_OUT;
					end else if (err_ovf_q) begin
						status_q <= ST_OVERFLOW;
						state_q <= S_DONE_OUT;
					end else begin
						root_q <= '0;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (root_q >= n_use) begin
						status_q <= ST_ACYCLIC;
						state_q <= S_DONE_OUT;
					end else state_q <= S_ROOTCHK;
				end
				S_ROOTCHK: begin
					if (nm_rmark == MARK_UNVISITED) begin
						sp_q <= (NW+1)'(1);
						state_q <= S_TOP;
					end else begin
						root_q <= root_q + (NW+1)'(1);
						state_q <= S_ROOT;
					end
				end
				S_TOP: begin
					if (sp_q == '0) begin
						root_q <= root_q + (NW+1)'(1);
						state_q <= S_ROOT;
					end else state_q <= S_TOPCHK;
				end
				S_TOPCHK: begin
					u_q <= sm_rnode;
					e_q <= sm_redge;
					if (sm_redge[EW]) state_q <= S_DONE;
					else state_q <= S_EDGE;
				end
				S_EDGE: begin
					v_q <= em_rtarget;
					state_q <= S_TARGET;
				end
				S_TARGET: begin
					if (nm_rmark == MARK_ON_PATH) begin
						status_q <= ST_CYCLE;
						state_q <= S_DONE_OUT;
					end else begin
						if (nm_rmark == MARK_UNVISITED) sp_q <= sp_q + (NW+1)'(1);
						state_q <= S_TOP;
					end
				end
				S_DONE: begin
					sp_q <= sp_q - (NW+1)'(1);
					state_q <= S_TOP;
				end
				S_DONE_OUT: begin
					out_valid <= 1'b1;
					clr_q <= '0;
					state_q <= S_CLEAR;
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	assign status = status_q;
	assign acyclic = (status_q == ST_ACYCLIC);

	// assertions
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)))
		else $error("result dropped");
	a_edges_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edges_q <= LW'(EDGES)) else $error("edge count overrun");
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= (NW+1)'(NODES)) else $error("stack overrun");
endmodule

// File: sv/dcd_edge_mem.sv
// ----------------------------------------------------------------------------
// dcd_edge_mem
// edge store: target node and next link per edge, registered read
// ----------------------------------------------------------------------------
module dcd_edge_mem (
	input  logic clk,
	input  logic we,
	input  logic [dcd_pkg::EW-1:0] waddr,
	input  dcd_pkg::node_t wtarget,
	input  dcd_pkg::link_t wnext,
	input  logic [dcd_pkg::EW-1:0] raddr,
	output dcd_pkg::node_t rtarget,
	output dcd_pkg::link_t rnext
);
	import dcd_pkg::*;
	node_t tgt_mem [EDGES];
	link_t nxt_mem [EDGES];
	always_ff @(posedge clk) begin
		if (we) begin
			tgt_mem[waddr] <= wtarget;
			nxt_mem[waddr] <= wnext;
		end
		rtarget <= tgt_mem[raddr];
		rnext <= nxt_mem[raddr];
	end
endmodule

// File: sv/dcd_node_mem.sv
// ----------------------------------------------------------------------------
// dcd_node_mem
// per-node list head and mark, one write and one registered read
// ----------------------------------------------------------------------------
module dcd_node_mem (
	input  logic clk,
	input  logic we,
	input  dcd_pkg::node_t waddr,
	input  dcd_pkg::link_t whead,
	input  dcd_pkg::mark_t wmark,
	input  dcd_pkg::node_t raddr,
	output dcd_pkg::link_t rhead,
	output dcd_pkg::mark_t rmark
);
	import dcd_pkg::*;
	link_t head_mem [NODES];
	mark_t mark_mem [NODES];
	always_ff @(posedge clk) begin
		if (we) begin
			head_mem[waddr] <= whead;
			mark_mem[waddr] <= wmark;
		end
		rhead <= head_mem[raddr];
		rmark <= mark_mem[raddr];
	end
endmodule

// File: sv/dcd_stack_mem.sv
// ----------------------------------------------------------------------------
// dcd_stack_mem
// walk stack: node and pending edge link per depth
// ----------------------------------------------------------------------------
module dcd_stack_mem (
	input  logic clk,
	input  logic we,
	input  dcd_pkg::node_t waddr,
	input  dcd_pkg::node_t wnode,
	input  dcd_pkg::link_t wedge,
	input  dcd_pkg::node_t raddr,
	output dcd_pkg::node_t rnode,
	output dcd_pkg::link_t redge
);
	import dcd_pkg::*;
	node_t node_mem [NODES];
	link_t edge_mem [NODES];
	always_ff @(posedge clk) begin
		if (we) begin
			node_mem[waddr] <= wnode;
			edge_mem[waddr] <= wedge;
		end
		rnode <= node_mem[raddr];
		redge <= edge_mem[raddr];
	end
endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the graph cycle detector
// ----------------------------------------------------------------------------
// Graphs are streamed in as edge transactions closed by a last-flagged item.
// A behavioral predictor keeps its own edge lists and runs a depth-first walk
// per graph to get acyclic/status. The results are compared in order against
// the monitored output transactions. The run covers several node counts
// (extremes included), range errors, random idling on both sides and one
// long receiver hold-off that stalls the input.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dcd_pkg::*;

	typedef struct packed {
		node_t src;
		node_t dst;
		logic  has_edge;
		logic  last;
	} edge_item_t;

	typedef struct packed {
		logic    acyclic;
		status_t status;
	} verdict_t;

	localparam int STALL_LIMIT = 400000;
	localparam int HOLD_AT = 10;
	localparam int HOLD_CYCLES = 3000;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CW-1:0] cfg_data;
	logic in_valid, in_ready;
	node_t source_node, target_node;
	logic edge_present, last_item;
	logic out_valid, out_ready, acyclic;
	status_t status;

	dag_cycle_detect dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.source_node(source_node), .target_node(target_node),
		.edge_present(edge_present), .last_item(last_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.acyclic(acyclic), .status(status)
	);

	// stimulus and scoreboard state
	edge_item_t pending_items[$];
	verdict_t   expected_verdicts[$];
	int         mismatches = 0;
	int         graphs_checked = 0;
	int         idle_cycles = 0;
	int         hold_off = 0;
	bit         hold_done = 0;
	int         out_wait = 0;
	bit         in_fired = 0;
	bit         out_fired = 0;
	bit         timed_out = 0;

	// predictor state: adjacency lists per source node
	int unsigned pred_nodes = 1;
	int          adj[NODES][$];
	int          pred_edges = 0;
	bit          err_range = 0, err_ovf = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// depth-first walk with an explicit stack
	function automatic bit graph_has_cycle(int unsigned n);
		mark_t mark[NODES];
		int stk_node[$];
		int stk_pos[$];
		int u, v, top;
		for (int i = 0; i < NODES; i++) mark[i] = MARK_UNVISITED;
		for (int r = 0; r < n; r++) begin
			if (mark[r] != MARK_UNVISITED) continue;
			mark[r] = MARK_ON_PATH;
			stk_node.push_back(r);
			stk_pos.push_back(adj[r].size() - 1);
			while (stk_node.size() > 0) begin
				top = stk_node.size() - 1;
				u = stk_node[top];
				// lists are walked newest edge first, like the hardware chain
				if (stk_pos[top] < 0) begin
					mark[u] = MARK_DONE;
					void'(stk_node.pop_back());
					void'(stk_pos.pop_back());
					continue;
				end
				v = adj[u][stk_pos[top]];
				stk_pos[top] = stk_pos[top] - 1;
				if (mark[v] == MARK_ON_PATH) return 1;
				if (mark[v] == MARK_UNVISITED) begin
					mark[v] = MARK_ON_PATH;
					stk_node.push_back(v);
					stk_pos.push_back(adj[v].size() - 1);
				end
			end
		end
		return 0;
	endfunction

	// one accepted input transaction into the predictor
	function automatic void predict_item(edge_item_t it);
		verdict_t vd;
		int unsigned n;
		n = (pred_nodes == 0) ? 1 : (pred_nodes > NODES ? NODES : pred_nodes);
		if (it.has_edge) begin
			if (it.src >= n || it.dst >= n) err_range = 1;
			else if (pred_edges >= EDGES) err_ovf = 1;
			else begin
				adj[it.src].push_back(int'(it.dst));
				pred_edges++;
			end
		end
		if (!it.last) return;
		if (err_range) vd.status = ST_RANGE;
		else if (err_ovf) vd.status = ST_OVERFLOW;
		else vd.status = graph_has_cycle(n) ? ST_CYCLE : ST_ACYCLIC;
		vd.acyclic = (vd.status == ST_ACYCLIC);
		expected_verdicts.push_back(vd);
		for (int i = 0; i < NODES; i++) adj[i].delete();
		pred_edges = 0;
		err_range = 0;
		err_ovf = 0;
	endfunction

	function automatic edge_item_t mk_item(int s, int d, bit e, bit l);
		edge_item_t it;
		it.src = node_t'(s);
		it.dst = node_t'(d);
		it.has_edge = e;
		it.last = l;
		return it;
	endfunction

	// queue one random graph over n nodes; mostly in range, acyclic or not
	task automatic queue_graph(int n, int n_edges, bit forward_only, bit allow_bad);
		int s, d;
		for (int k = 0; k < n_edges; k++) begin
			s = $urandom_range(n - 1);
			d = $urandom_range(n - 1);
			if (forward_only && s > d) begin
				int t;
				t = s; s = d; d = t;
			end
			if (forward_only && s == d) d = (d + 1 < n) ? d + 1 : d;
			if (forward_only && s == d) continue;
			if (allow_bad && $urandom_range(15) == 0) d = $urandom_range(1023);
			// occasional empty item inside the graph
			if ($urandom_range(9) == 0) pending_items.push_back(mk_item(s, d, 0, 0));
			pending_items.push_back(mk_item(s, d, 1, 0));
		end
		if ($urandom_range(1))
			pending_items.push_back(mk_item($urandom_range(1023), $urandom_range(1023), 0, 1));
		else begin
			s = $urandom_range(n - 1);
			d = forward_only ? n - 1 : $urandom_range(n - 1);
			if (forward_only && s == d) pending_items.push_back(mk_item(s, d, 0, 1));
			else pending_items.push_back(mk_item(s, d, 1, 1));
		end
	endtask

	// driver: random gap between transactions, payload held until accepted
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 0;
			source_node <= '0;
			target_node <= '0;
			edge_present <= 0;
			last_item <= 0;
			idle_cycles <= 0;
		end else if (in_valid && !in_fired) begin
			// keep offering the same transaction
		end else if (idle_cycles > 0) begin
			idle_cycles <= idle_cycles - 1;
			in_valid <= 0;
		end else if (pending_items.size() > 0) begin
			in_valid <= 1;
			{source_node, target_node, edge_present, last_item} <= pending_items.pop_front();
			idle_cycles <= $urandom_range(4);
		end else begin
			in_valid <= 0;
		end
	end

	// input acceptance into the predictor
	always @(posedge clk) begin
		in_fired <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			predict_item({source_node, target_node, edge_present, last_item});
	end

	// receiver: random wait per result, plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 0;
			hold_off <= 0;
			hold_done <= 0;
			out_wait <= $urandom_range(4);
		end else if (!hold_done && graphs_checked == HOLD_AT) begin
			hold_done <= 1;
			hold_off <= HOLD_CYCLES;
			out_ready <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 0;
		end else if (out_fired) begin
			out_ready <= 0;
			out_wait <= $urandom_range(4);
		end else if (out_valid && !out_ready) begin
			if (out_wait > 0) out_wait <= out_wait - 1;
			else out_ready <= 1;
		end
	end

	// monitor: compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		verdict_t want;
		out_fired <= arst_n && out_valid && out_ready;
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected result acyclic=%0b status=%0d",
					$time, acyclic, status);
				mismatches++;
			end else begin
				want = expected_verdicts.pop_front();
				if (want.acyclic !== acyclic) begin
					$display("%0t: acyclic expected %0b actual %0b",
						$time, want.acyclic, acyclic);
					mismatches++;
				end
				if (want.status !== status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, status);
					mismatches++;
				end
				graphs_checked++;
			end
		end
	end

	// watchdog: count cycles with no transaction on any channel
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("watchdog expired after %0d idle cycles", STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// write node_count while the block is idle
	task automatic write_node_count(int value);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= CW'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		pred_nodes = value;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_verdicts.size() > 0)
			@(posedge clk);
		// clearing pass after a result
		repeat (1100) @(posedge clk);
	endtask

	int count_settings[] = '{2, 1024, 0, 1, 7, 2047, 40, 300};

	initial begin
		cfg_valid = 0;
		cfg_data = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset count of one node
		pending_items.push_back(mk_item(0, 0, 0, 1));
		pending_items.push_back(mk_item(0, 0, 1, 1));
		pending_items.push_back(mk_item(0, 1, 1, 1));
		drain();

		write_node_count(1024);
		// self loop at the top node, extremes of fields
		pending_items.push_back(mk_item(1023, 1023, 1, 1));
		// chain 0 -> 1023 -> 512, no cycle, then close with edge-less last
		pending_items.push_back(mk_item(0, 1023, 1, 0));
		pending_items.push_back(mk_item(1023, 512, 1, 0));
		pending_items.push_back(mk_item(5, 5, 0, 0));
		pending_items.push_back(mk_item(682, 341, 0, 1));
		// duplicate edges and a two-node cycle closed by the last item
		pending_items.push_back(mk_item(341, 682, 1, 0));
		pending_items.push_back(mk_item(341, 682, 1, 0));
		pending_items.push_back(mk_item(682, 341, 1, 1));
		drain();

		write_node_count(3);
		// out of range then valid cycle: range wins
		pending_items.push_back(mk_item(0, 3, 1, 0));
		pending_items.push_back(mk_item(0, 1, 1, 0));
		pending_items.push_back(mk_item(1, 0, 1, 1));
		pending_items.push_back(mk_item(1, 2, 1, 0));
		pending_items.push_back(mk_item(2, 0, 1, 0));
		pending_items.push_back(mk_item(0, 1, 1, 1));
		drain();

		// random graphs across several node counts
		foreach (count_settings[i]) begin
			int n;
			write_node_count(count_settings[i]);
			n = (count_settings[i] == 0) ? 1
				: (count_settings[i] > NODES ? NODES : count_settings[i]);
			for (int g = 0; g < 7; g++)
				queue_graph(n, $urandom_range(1, (n < 4) ? 4 : 12),
					$urandom_range(1) == 1, g % 3 == 2);
			drain();
		end

		$display("checked %0d graph results over %0d node count settings",
			graphs_checked, count_settings.size() + 3);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// File: sim.f
sv/dcd_pkg.sv
sv/dcd_edge_mem.sv
sv/dcd_node_mem.sv
sv/dcd_stack_mem.sv
sv/dag_cycle_detect.sv
bench/tb_top.sv
